// ===== hw/rtl/cosf_pkg.sv =====
// cosf_pkg: shared types, codes and constants of the clock offset sync filter.
// No dependencies. Also holds the elaboration-time gain weight function.
`default_nettype none

package cosf_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned NS_W = 20;
    localparam logic [NS_W-1:0] NS_PER_MS = 20'd1000000;
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 20;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_SEND    = 3'd1,
        KIND_ACCEPT  = 3'd2,
        KIND_DEV_REJ = 3'd3,
        KIND_RESET   = 3'd4,
        KIND_RTT_REJ = 3'd5,
        KIND_RTT_WARN = 3'd6
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RTT_MS   = 8'd0,
        REG_MAX_DEV_MS   = 8'd1,
        REG_MAX_HIGH_DEV = 8'd2,
        REG_MAX_HIGH_RTT = 8'd3,
        REG_ALPHA_INIT   = 8'd4,
        REG_ALPHA_FINAL  = 8'd5,
        REG_BETA_INIT    = 8'd6,
        REG_BETA_FINAL   = 8'd7
    } reg_idx_t;

    // shift-and-subtract long division, returns {quotient, remainder}
    function automatic logic [127:0] udivmod(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    // blend weight p = 1 - exp(-s / (2 (W - s))), Q0.16; elaboration only
    function automatic logic [15:0] rom_p(input int unsigned w, input int unsigned s);
        longint unsigned d;
        longint unsigned k;
        longint unsigned f;
        longint unsigned term;
        longint unsigned e;
        longint unsigned p;
        longint sum;
        int unsigned i;
        logic [127:0] qr;
        d = 64'(2 * (w - s));
        qr = udivmod(64'(s), d);
        k = qr[127:64];
        if (k >= 12) return 16'hFFFF;
        qr = udivmod(qr[63:0] << 32, d);
        f = qr[127:64];
        term = 64'h1_0000_0000;
        sum = 64'sh1_0000_0000;
        for (i = 1; i <= 20; i++) begin
            qr = udivmod((term * f) >> 32, 64'(i));
            term = qr[127:64];
            if (i[0]) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        e = (sum < 0) ? 64'd0 : longint'(sum);
        if (e > 64'h1_0000_0000) e = 64'h1_0000_0000;
        for (i = 0; i < k; i++) e = (e * 64'd1580030169 + 64'h8000_0000) >> 32;
        p = ((64'h1_0000_0000 - e) + 64'd32768) >> 16;
        return (p > 64'd65535) ? 16'hFFFF : p[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cosf_mul.sv =====
// cosf_mul: shared unsigned 32 x 20 multiplier with registered product.
// Depends on cosf_pkg for operand widths.
`default_nettype none

module cosf_mul
    import cosf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [MUL_A_W-1:0] op_a,
    input  wire logic [MUL_B_W-1:0] op_b,
    output logic      [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/clock_offset_sync_filter.sv =====
// clock_offset_sync_filter: two-way time-sync offset estimator, double
// exponential smoothing in Q48.16. Depends on cosf_pkg and cosf_mul.
// Send and ignore items go straight to the result; rejects pass the offset, limit
// and deviation states; accepted samples also form both gains, and later ones
// blend level and trend. One item at a time: the next input waits for the result load.
// Reset: aresetn synchronous active low; clears filter state, restores register
// defaults, drops output valid.
`default_nettype none

module clock_offset_sync_filter
    import cosf_pkg::*;
#(
    parameter int unsigned CONV_WINDOW = 500
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [191:0]          s_axis_tdata,  // local_now, echo_time, remote_time
    input  wire logic [1:0]            s_axis_tuser,  // action, from_peer
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [191:0]          m_axis_tdata,  // send_tc1, send_ts1, offset_out
    output logic      [KIND_W-1:0]     m_axis_tuser   // kind
);

    localparam int unsigned CNT_W = $clog2(CONV_WINDOW + 1);
    localparam int unsigned IDX_W = (CONV_WINDOW > 1) ? $clog2(CONV_WINDOW) : 1;
    localparam int unsigned ROM_N = 2 ** IDX_W;
    localparam logic [63:0] SGN = 64'h8000_0000_0000_0000;

    // weight table, computed at elaboration; entries past the window unused
    function automatic logic [ROM_N*16-1:0] build_rom();
        logic [ROM_N*16-1:0] r;
        r = '0;
        for (int unsigned s = 0; s < ROM_N; s++) begin
            if (s < CONV_WINDOW) r[s*16 +: 16] = rom_p(CONV_WINDOW, s);
            else r[s*16 +: 16] = 16'hFFFF;
        end
        return r;
    endfunction

    localparam logic [ROM_N*16-1:0] P_ROM = build_rom();

    function automatic logic s_lt(input logic [63:0] a, input logic [63:0] b);
        return (a ^ SGN) < (b ^ SGN);
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SGN : ~SGN;
        return r;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SGN : ~SGN;
        return r;
    endfunction

    function automatic logic [63:0] to_q(input logic [63:0] o);
        if (!o[63] && o > 64'h0000_7FFF_FFFF_FFFF) return ~SGN;
        if (o[63] && o < 64'hFFFF_8000_0000_0000) return SGN;
        return {o[47:0], 16'h0};
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE, ST_OFF, ST_SQ, ST_RTT, ST_DEV, ST_GA1, ST_GA2, ST_GB1, ST_GB2,
        ST_PRED, ST_BL0, ST_BL1, ST_BL2, ST_BL3, ST_SKW, ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [15:0] max_rtt_ms_reg, max_dev_ms_reg;
    logic [7:0]  max_high_dev_reg, max_high_rtt_reg;
    logic [15:0] alpha_ini_reg, alpha_fin_reg, beta_ini_reg, beta_fin_reg;

    // filter state
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      est_reg, skew_reg;
    logic [7:0]       dev_run_reg, rtt_run_reg;

    // per-item working registers
    logic [63:0] now_reg, echo_reg, remote_reg;
    logic [63:0] off_reg, rtt_reg, sq_reg, dev_reg, prev_reg;
    logic [35:0] rtt_lim_reg;
    logic [51:0] dev_lim_reg;
    logic        rtt_ok_reg;
    logic [15:0] p_reg, ga_reg, gb_reg;
    logic [63:0] acc_reg;
    logic [63:0] bl_x_reg, bl_y_reg, bl_m_reg;
    logic [15:0] bl_g_reg;
    logic        bl_lt_reg, bl_phase_reg;

    // staged result
    logic [KIND_W-1:0] res_kind_reg;
    logic [63:0]       res_tc1_reg, res_ts1_reg;

    // output register
    logic              m_valid_reg;
    logic [KIND_W-1:0] m_kind_reg;
    logic [63:0]       m_tc1_reg, m_ts1_reg, m_off_reg;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    cosf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    logic        conv;
    logic [16:0] p_inv;
    logic [63:0] a_diff, b_diff;
    logic [63:0] bl_q, bl_r;
    logic [16:0] gain_sum_hi;
    logic [7:0]  dev_run_inc, rtt_run_inc;
    logic        emit_go;

    assign conv  = (cnt_reg >= CNT_W'(CONV_WINDOW));
    assign p_inv = 17'h1_0000 - 17'(p_reg);
    assign a_diff = now_reg - remote_reg;
    assign b_diff = echo_reg - remote_reg;
    assign bl_q  = acc_reg + 64'((prod[48:0] + 49'd32768) >> 16);
    assign bl_r  = bl_lt_reg ? bl_x_reg - bl_q : bl_x_reg + bl_q;
    assign gain_sum_hi = 17'((65'(acc_reg) + 65'(prod) + 65'd32768) >> 16);
    assign dev_run_inc = (dev_run_reg == 8'hFF) ? dev_run_reg : dev_run_reg + 8'd1;
    assign rtt_run_inc = (rtt_run_reg == 8'hFF) ? rtt_run_reg : rtt_run_reg + 8'd1;
    // result register loads when empty or emptying this cycle
    assign emit_go = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);

    // multiplier operand selection: issued in one state, product seen in the next
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_OFF: begin
                mul_a = MUL_A_W'(max_rtt_ms_reg);
                mul_b = NS_PER_MS;
            end
            ST_SQ: begin
                mul_a = MUL_A_W'(max_dev_ms_reg);
                mul_b = NS_PER_MS;
            end
            ST_DEV: begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = MUL_B_W'(alpha_fin_reg);
            end
            ST_GA1: begin
                mul_a = MUL_A_W'(p_inv);
                mul_b = MUL_B_W'(alpha_ini_reg);
            end
            ST_GA2: begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = MUL_B_W'(beta_fin_reg);
            end
            ST_GB1: begin
                mul_a = MUL_A_W'(p_inv);
                mul_b = MUL_B_W'(beta_ini_reg);
            end
            ST_BL1: begin
                mul_a = bl_m_reg[63:32];
                mul_b = MUL_B_W'(bl_g_reg);
            end
            ST_BL2: begin
                mul_a = bl_m_reg[31:0];
                mul_b = MUL_B_W'(bl_g_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            max_rtt_ms_reg   <= 16'd10;
            max_dev_ms_reg   <= 16'd100;
            max_high_dev_reg <= 8'd5;
            max_high_rtt_reg <= 8'd5;
            alpha_ini_reg    <= 16'd3277;
            alpha_fin_reg    <= 16'd197;
            beta_ini_reg     <= 16'd3277;
            beta_fin_reg     <= 16'd197;
            cnt_reg          <= '0;
            est_reg          <= '0;
            skew_reg         <= '0;
            dev_run_reg      <= '0;
            rtt_run_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MAX_RTT_MS:   max_rtt_ms_reg   <= cfg_wdata;
                    REG_MAX_DEV_MS:   max_dev_ms_reg   <= cfg_wdata;
                    REG_MAX_HIGH_DEV: max_high_dev_reg <= cfg_wdata[7:0];
                    REG_MAX_HIGH_RTT: max_high_rtt_reg <= cfg_wdata[7:0];
                    REG_ALPHA_INIT:   alpha_ini_reg    <= cfg_wdata;
                    REG_ALPHA_FINAL:  alpha_fin_reg    <= cfg_wdata;
                    REG_BETA_INIT:    beta_ini_reg     <= cfg_wdata;
                    REG_BETA_FINAL:   beta_fin_reg     <= cfg_wdata;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_axis_tready && !emit_go) m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        now_reg     <= s_axis_tdata[63:0];
                        echo_reg    <= s_axis_tdata[127:64];
                        remote_reg  <= s_axis_tdata[191:128];
                        res_tc1_reg <= '0;
                        res_ts1_reg <= '0;
                        if (!s_axis_tuser[0]) begin
                            // request tick: stamp 0, our time
                            res_kind_reg <= KIND_SEND;
                            res_ts1_reg  <= s_axis_tdata[63:0];
                            state_reg    <= ST_EMIT;
                        end else if (!s_axis_tuser[1]) begin
                            res_kind_reg <= KIND_NONE;
                            state_reg    <= ST_EMIT;
                        end else if (s_axis_tdata[191:128] == 64'd0) begin
                            // peer request: answer with echo
                            res_kind_reg <= KIND_SEND;
                            res_tc1_reg  <= s_axis_tdata[63:0];
                            res_ts1_reg  <= s_axis_tdata[127:64];
                            state_reg    <= ST_EMIT;
                        end else begin
                            state_reg <= ST_OFF;
                        end
                    end
                end
                ST_OFF: begin
                    // floor((a + b) / 2) without overflow
                    off_reg <= {a_diff[63], a_diff[63:1]} + {b_diff[63], b_diff[63:1]}
                               + 64'(a_diff[0] & b_diff[0]);
                    rtt_reg <= now_reg - echo_reg;
                    p_reg   <= P_ROM[16*cnt_reg[IDX_W-1:0] +: 16];
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    sq_reg      <= to_q(off_reg);
                    rtt_lim_reg <= prod[35:0];
                    state_reg   <= ST_RTT;
                end
                ST_RTT: begin
                    dev_lim_reg <= {prod[35:0], 16'h0};
                    rtt_ok_reg  <= rtt_reg < 64'(rtt_lim_reg);
                    dev_reg     <= s_lt(sq_reg, est_reg) ? est_reg - sq_reg : sq_reg - est_reg;
                    state_reg   <= ST_DEV;
                end
                ST_DEV: begin
                    if (!rtt_ok_reg) begin
                        if (rtt_run_inc > max_high_rtt_reg) begin
                            rtt_run_reg  <= '0;
                            res_kind_reg <= KIND_RTT_WARN;
                        end else begin
                            rtt_run_reg  <= rtt_run_inc;
                            res_kind_reg <= KIND_RTT_REJ;
                        end
                        state_reg <= ST_EMIT;
                    end else if (conv && dev_reg > 64'(dev_lim_reg)) begin
                        if (dev_run_inc > max_high_dev_reg) begin
                            // too many outliers: restart the filter
                            cnt_reg      <= '0;
                            est_reg      <= '0;
                            skew_reg     <= '0;
                            dev_run_reg  <= '0;
                            rtt_run_reg  <= '0;
                            res_kind_reg <= KIND_RESET;
                        end else begin
                            dev_run_reg  <= dev_run_inc;
                            res_kind_reg <= KIND_DEV_REJ;
                        end
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_GA1;
                    end
                end
                ST_GA1: begin
                    acc_reg   <= 64'(prod);
                    state_reg <= ST_GA2;
                end
                ST_GA2: begin
                    ga_reg    <= conv ? alpha_fin_reg : gain_sum_hi[15:0];
                    state_reg <= ST_GB1;
                end
                ST_GB1: begin
                    acc_reg   <= 64'(prod);
                    state_reg <= ST_GB2;
                end
                ST_GB2: begin
                    gb_reg <= conv ? beta_fin_reg : gain_sum_hi[15:0];
                    if (cnt_reg == '0) begin
                        // first sample seeds the estimate
                        est_reg      <= sq_reg;
                        cnt_reg      <= cnt_reg + CNT_W'(1);
                        dev_run_reg  <= '0;
                        rtt_run_reg  <= '0;
                        res_kind_reg <= KIND_ACCEPT;
                        state_reg    <= ST_EMIT;
                    end else begin
                        state_reg <= ST_PRED;
                    end
                end
                ST_PRED: begin
                    prev_reg     <= est_reg;
                    bl_x_reg     <= sat_add(est_reg, skew_reg);
                    bl_y_reg     <= sq_reg;
                    bl_g_reg     <= ga_reg;
                    bl_phase_reg <= 1'b0;
                    state_reg    <= ST_BL0;
                end
                ST_BL0: begin
                    bl_lt_reg <= s_lt(bl_y_reg, bl_x_reg);
                    bl_m_reg  <= s_lt(bl_y_reg, bl_x_reg) ? bl_x_reg - bl_y_reg
                                                          : bl_y_reg - bl_x_reg;
                    state_reg <= ST_BL1;
                end
                ST_BL1: begin
                    state_reg <= ST_BL2;
                end
                ST_BL2: begin
                    acc_reg   <= {prod[47:0], 16'h0};
                    state_reg <= ST_BL3;
                end
                ST_BL3: begin
                    if (!bl_phase_reg) begin
                        est_reg   <= bl_r;
                        state_reg <= ST_SKW;
                    end else begin
                        skew_reg     <= bl_r;
                        if (!conv) cnt_reg <= cnt_reg + CNT_W'(1);
                        dev_run_reg  <= '0;
                        rtt_run_reg  <= '0;
                        res_kind_reg <= KIND_ACCEPT;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_SKW: begin
                    bl_x_reg     <= skew_reg;
                    bl_y_reg     <= sat_sub(est_reg, prev_reg);
                    bl_g_reg     <= gb_reg;
                    bl_phase_reg <= 1'b1;
                    state_reg    <= ST_BL0;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= res_kind_reg;
                        m_tc1_reg   <= res_tc1_reg;
                        m_ts1_reg   <= res_ts1_reg;
                        m_off_reg   <= {{16{est_reg[63]}}, est_reg[63:16]};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {m_off_reg, m_ts1_reg, m_tc1_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/cosf_chk.sv =====
// cosf_chk: port-level checks for clock_offset_sync_filter, with bind.
// Depends on cosf_pkg for result kind codes.
`default_nettype none

module cosf_chk
    import cosf_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [191:0]      m_axis_tdata,
    input wire logic [KIND_W-1:0] m_axis_tuser
);

    // one item in flight: input closes after each transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser <= KIND_RTT_WARN))
        else $error("undefined result kind");

    a_send_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != KIND_SEND) |-> (m_axis_tdata[127:0] == 128'd0))
        else $error("message stamps set on non-send result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind clock_offset_sync_filter cosf_chk u_cosf_chk (.*);

`default_nettype wire
